// ===== src/can_acceptance_filter_table_macros.svh =====
// ----------------------------------------------------------------------------
// CAN acceptance filter table - assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CAN_ACCEPTANCE_FILTER_TABLE_MACROS_SVH
`define CAN_ACCEPTANCE_FILTER_TABLE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CAFT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CAFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/caft_pkg.sv =====
// ----------------------------------------------------------------------------
// caft_pkg
// Types, codes and constants shared by the acceptance filter table modules.
// ----------------------------------------------------------------------------
package caft_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = IDX_W + 1;

	localparam int ENTRY_IDX_W = 8;
	localparam int SFF_W       = 11;
	localparam int ID_W        = 29;
	localparam int FRAME_ID_W  = 32;
	localparam int LEN_W       = 4;
	localparam int DATA_W      = 64;
	localparam int STATUS_W    = 2;
	localparam int MATCH_W     = 5;
	localparam int EIU_W       = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 6;

	localparam int FLAG_ERR_BIT = 29;

	localparam logic ACTION_CONFIG = 1'b0;
	localparam logic ACTION_FRAME  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_WRITTEN  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ILLEGAL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MATCHED  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RX_ENABLE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'd1;

	localparam logic [EIU_W-1:0] EIU_RESET = 6'd32;

	typedef struct packed {
		logic                    action;
		logic [ENTRY_IDX_W-1:0]  entry_index;
		logic [SFF_W-1:0]        filter_ident;
		logic [SFF_W-1:0]        filter_mask;
		logic                    filter_rtr;
		logic [FRAME_ID_W-1:0]   frame_id;
		logic [LEN_W-1:0]        frame_length;
		logic [DATA_W-1:0]       frame_data;
	} in_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MATCH_W-1:0]  match_index;
		logic [ID_W-1:0]     out_ident;
		logic [LEN_W-1:0]    out_length;
		logic [DATA_W-1:0]   out_data;
	} out_req_t;

	// mask_full set: mask also covers ID bits 28..11 (the reset all-ones mask)
	typedef struct packed {
		logic             rtr;
		logic [SFF_W-1:0] ident;
		logic             mask_full;
		logic [SFF_W-1:0] mask;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{rtr: 1'b0, ident: '0, mask_full: 1'b1, mask: '1};

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

	typedef struct packed {
		logic             action;
		logic [ID_W-1:0]  key_id;
		logic [IDX_W-1:0] own_index;
		logic [IDX_W-1:0] entry_index;
	} cmp_req_t;

endpackage

// ===== src/caft_filter_mem.sv =====
// ----------------------------------------------------------------------------
// caft_filter_mem
// Filter entry store: one write port, one registered read port, valid bits.
// ----------------------------------------------------------------------------
module caft_filter_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  caft_pkg::mem_wr_t wr,
	input  caft_pkg::mem_rd_t rd,
	output caft_pkg::entry_t  rd_data
);
	import caft_pkg::*;

	entry_t             mem_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	entry_t             word_s1;
	logic               vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			word_s1 <= mem_q[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				vld_s1 <= valid_q[rd.addr];
			end
		end
	end

	// unwritten entries read as the reset entry
	assign rd_data = vld_s1 ? word_s1 : ENTRY_RESET;

endmodule

// ===== src/caft_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// caft_cmp_unit
// Shared entry comparator: masked ID match or duplicate identifier check.
// ----------------------------------------------------------------------------
module caft_cmp_unit (
	input  caft_pkg::cmp_req_t req,
	input  caft_pkg::entry_t   entry,
	output logic               hit
);
	import caft_pkg::*;

	logic id_hit;
	logic dup_hit;
	logic hi_zero;

	always_comb begin
		hi_zero = (req.key_id[ID_W-1:SFF_W] == '0);
		// RTR flag of the key is always clear, so an RTR entry never matches
		id_hit  = !entry.rtr
			&& (((req.key_id[SFF_W-1:0] ^ entry.ident) & entry.mask) == '0)
			&& (!entry.mask_full || hi_zero);
		dup_hit = (req.key_id[SFF_W-1:0] != '0) && hi_zero && !entry.rtr
			&& (entry.ident == req.key_id[SFF_W-1:0])
			&& (req.entry_index != req.own_index);
		hit     = (req.action == ACTION_FRAME) ? id_hit : dup_hit;
	end

endmodule

// ===== src/caft_ctrl.sv =====
// ----------------------------------------------------------------------------
// caft_ctrl
// Sequencer: takes a request, scans the entries one a cycle, holds the result.
// ----------------------------------------------------------------------------
`include "can_acceptance_filter_table_macros.svh"

module caft_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rx_enable,
	input  logic [caft_pkg::CNT_W-1:0] active_size,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  caft_pkg::in_req_t          item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output caft_pkg::out_req_t         result,
	output caft_pkg::mem_rd_t          mem_rd,
	output caft_pkg::mem_wr_t          mem_wr,
	output caft_pkg::cmp_req_t         cmp_req,
	input  logic                       cmp_hit
);
	import caft_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t           state_q;
	in_req_t          req_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] issue_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	out_req_t         res_q;
	out_req_t         out_q;
	logic             out_valid_q;

	logic     item_acc;
	logic     early;
	logic     issue;
	logic     scan_hit;
	logic     scan_end;
	logic     load_res;
	logic     emit;
	out_req_t res_next;

	always_comb begin
		item_acc = (state_q == ST_IDLE) && item_valid;
		early    = (item.action == ACTION_CONFIG)
			? (item.entry_index >= ENTRY_IDX_W'(active_size))
			: (!rx_enable || item.frame_id[FLAG_ERR_BIT]);
		issue    = (state_q == ST_SCAN) && (issue_q < n_q);
		scan_hit = (state_q == ST_SCAN) && rd_vld_s1 && cmp_hit;
		scan_end = (state_q == ST_SCAN) && !rd_vld_s1 && (issue_q == n_q);
		load_res = (item_acc && early) || scan_hit || scan_end;
		emit     = (state_q == ST_EMIT) && (!out_valid_q || result_ready);

		res_next        = '0;
		res_next.status = STATUS_REJECTED;
		if (state_q == ST_IDLE) begin
			if (item.action == ACTION_CONFIG) begin
				res_next.status = STATUS_ILLEGAL;
			end
		end else if (scan_hit) begin
			if (req_q.action == ACTION_FRAME) begin
				res_next.status      = STATUS_MATCHED;
				res_next.match_index = MATCH_W'(rd_idx_s1);
				res_next.out_ident   = req_q.frame_id[ID_W-1:0];
				res_next.out_length  = req_q.frame_length;
				res_next.out_data    = req_q.frame_data;
			end else begin
				res_next.status = STATUS_ILLEGAL;
			end
		end else if (req_q.action == ACTION_CONFIG) begin
			res_next.status = STATUS_WRITTEN;
		end

		mem_rd.en   = issue;
		mem_rd.addr = issue_q[IDX_W-1:0];

		mem_wr.en             = scan_end && (req_q.action == ACTION_CONFIG);
		mem_wr.addr           = req_q.entry_index[IDX_W-1:0];
		mem_wr.data.rtr       = req_q.filter_rtr;
		mem_wr.data.ident     = req_q.filter_ident;
		mem_wr.data.mask_full = 1'b0;
		mem_wr.data.mask      = req_q.filter_mask;

		cmp_req.action      = req_q.action;
		cmp_req.key_id      = (req_q.action == ACTION_FRAME)
			? req_q.frame_id[ID_W-1:0] : ID_W'(req_q.filter_ident);
		cmp_req.own_index   = req_q.entry_index[IDX_W-1:0];
		cmp_req.entry_index = rd_idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						n_q     <= active_size;
						issue_q <= '0;
						state_q <= early ? ST_EMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_hit || scan_end) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			req_q <= item;
		end
		rd_idx_s1 <= issue_q[IDX_W-1:0];
		if (load_res) begin
			res_q <= res_next;
		end
		if (emit) begin
			out_q <= res_q;
		end
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	`CAFT_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready,
		"request taken but still ready")
	`CAFT_ASSERT_SAME(a_read_in_range, rd_vld_s1, CNT_W'(rd_idx_s1) < n_q,
		"entry read beyond active size")
	`CAFT_ASSERT_SAME(a_write_only_config, mem_wr.en,
		req_q.action == ACTION_CONFIG && state_q == ST_SCAN,
		"entry written outside a configure request")
	`CAFT_ASSERT_SAME(a_unmatched_zero, result_valid && result.status != STATUS_MATCHED,
		result.match_index == '0 && result.out_ident == '0 && result.out_data == '0,
		"non-matched result carries frame fields")

endmodule

// ===== src/can_acceptance_filter_table.sv =====
// ----------------------------------------------------------------------------
// can_acceptance_filter_table
// Table of 32 CAN receive filters searched by one shared comparator.
// ----------------------------------------------------------------------------
// Requests enter on item_valid/item_ready as an in_req_t. A configure request
// writes one filter entry; a frame request is checked against the active
// entries and the lowest matching entry is reported with the frame. Every
// request gives exactly one result on result_valid/result_ready.
// A configure request with an index beyond the active size or a dropped frame
// (reception off or error flag set) gives its result without a scan.
// Otherwise the entries are read one per cycle through the single comparator:
// the n active entries (at most 32), stopping at the first match or
// duplicate. One request is in work at a time; item_ready is low meanwhile.
// The finished result sits in an output register, so a new request is taken
// while it waits; a stalled receiver holds the block after its next request.
// Registers are written on cfg_we (index 0 rx_enable, 1 entries_in_use); the
// user must write them only while idle, unchecked by the block. Reset: 32
// entries in use, rx off, every entry ident 0, all-ones mask; no clearing pass.
// ----------------------------------------------------------------------------
module can_acceptance_filter_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  caft_pkg::in_req_t               item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output caft_pkg::out_req_t              result,
	input  logic                            cfg_we,
	input  logic [caft_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [caft_pkg::CFG_DATA_W-1:0] cfg_data
);
	import caft_pkg::*;

	logic             rx_enable_q;
	logic [EIU_W-1:0] entries_in_use_q;
	logic [CNT_W-1:0] active_size;
	mem_rd_t          mem_rd;
	mem_wr_t          mem_wr;
	entry_t           mem_rd_data;
	cmp_req_t         cmp_req;
	logic             cmp_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_enable_q      <= 1'b0;
			entries_in_use_q <= EIU_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RX_ENABLE: begin
					rx_enable_q <= cfg_data[0];
				end
				REG_ENTRIES_IN_USE: begin
					entries_in_use_q <= EIU_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign active_size = (entries_in_use_q >= EIU_W'(ENTRIES))
		? CNT_W'(ENTRIES) : CNT_W'(entries_in_use_q);

	caft_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_enable    (rx_enable_q),
		.active_size  (active_size),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mem_rd       (mem_rd),
		.mem_wr       (mem_wr),
		.cmp_req      (cmp_req),
		.cmp_hit      (cmp_hit)
	);

	caft_filter_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (mem_rd_data)
	);

	caft_cmp_unit u_cmp (
		.req   (cmp_req),
		.entry (mem_rd_data),
		.hit   (cmp_hit)
	);

endmodule
